@@ src/c2rg_pkg.sv @@
// Shared types, codes and the border mirror function for the 2D convolution block.
package c2rg_pkg;

  localparam int DIM_W   = 9;
  localparam int KDIM_W  = 3;
  localparam int IDX_W   = 12;
  localparam int PROD_W  = 25;
  localparam int ACC_W   = 36;
  localparam int OUT_W   = 32;
  localparam int CFG_I_W = 3;

  localparam logic [1:0] KIND_COEF = 2'd0;
  localparam logic [1:0] KIND_PIX  = 2'd1;
  localparam logic [1:0] KIND_OUT  = 2'd2;

  localparam logic [CFG_I_W-1:0] CFG_IMG_H = 3'd0;
  localparam logic [CFG_I_W-1:0] CFG_IMG_W = 3'd1;
  localparam logic [CFG_I_W-1:0] CFG_KER_H = 3'd2;
  localparam logic [CFG_I_W-1:0] CFG_KER_W = 3'd3;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] coefficient;
    logic [7:0]         pixel;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] filtered;
    logic [7:0]         out_row;
    logic [7:0]         out_col;
    logic               last;
  } out_word_t;

  // reflect-101: mirror about the edge without repeating it
  function automatic logic [DIM_W-1:0] mirror101(input logic signed [IDX_W-1:0] idx,
                                                 input logic [DIM_W-1:0] size);
    logic signed [IDX_W-1:0] period;
    logic signed [IDX_W-1:0] m;
    logic [DIM_W-1:0]        res;
    period = $signed({2'b00, size, 1'b0}) - 12'sd2;
    m = idx;
    for (int i = 0; i < 4; i++) begin
      if (m < 0) begin
        m = m + period;
      end else if (m >= period) begin
        m = m - period;
      end
    end
    if (m >= $signed({3'b000, size})) begin
      m = period - m;
    end
    res = m[DIM_W-1:0];
    if (size <= 9'd1) begin
      res = '0;
    end
    return res;
  endfunction

endpackage

@@ src/c2rg_divider.sv @@
// Bit-serial restoring divider giving raster row and column from a pixel index.
module c2rg_divider import c2rg_pkg::*; #(
  parameter int NUM_W = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DIM_W-1:0] divisor,
  output logic             done,
  output logic [NUM_W-1:0] quot,
  output logic [DIM_W-1:0] rem
);

  localparam int SC_W = $clog2(NUM_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [SC_W-1:0]  step_r;
  logic [NUM_W-1:0] q_r;
  logic [DIM_W-1:0] rem_r;
  logic [DIM_W:0]   trial;
  logic             fits;

  assign trial = {rem_r, q_r[NUM_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= SC_W'(NUM_W);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == SC_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      q_r   <= NUM_W'({q_r, fits});
      rem_r <= fits ? DIM_W'(trial - {1'b0, divisor}) : trial[DIM_W-1:0];
    end
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = rem_r;

endmodule

@@ src/conv2d_reflect_gray_top.sv @@
// Top level of the 2D convolution block with reflect-101 borders.
// Usage:
//   Input channel (in_valid/in_ready/in_word) carries one word per item: kind 0 stores the
//   next kernel coefficient, kind 1 the next pixel (both in raster order), kind 2 asks for
//   the next output pixel, kind 3 is dropped. Loads do not stall the input.
//   Output channel (out_valid/out_ready/out_word) returns one word per kind 2 item: the
//   saturated Q19.12 sum, its row and column, and last on the final pixel of the image.
//   Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data) sets image and kernel sizes;
//   write it only while the block is idle.
// A kind 2 item is worked one tap a cycle through the pixel memory read port and the
//   single multiplier. The first output after a configuration write also waits for the
//   serial divider that recovers row and column, unless the output position lies beyond
//   the new image and restarts at 0.
// One output item is computed at a time; loads are taken while a result waits.
// Reset clears counters and sets all sizes to 1; the stores are not cleared.
// A stalled receiver holds out_word; the block still takes loads and finishes the next
//   output into its finish state, where it waits for the output register to free up.
module conv2d_reflect_gray_top import c2rg_pkg::*; #(
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_KERNEL = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_word_t           in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output out_word_t          out_word,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CFG_I_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]   cfg_data
);

  localparam int H_LIM     = (MAX_HEIGHT > 511) ? 511 : MAX_HEIGHT;
  localparam int W_LIM     = (MAX_WIDTH > 511) ? 511 : MAX_WIDTH;
  localparam int K_LIM     = (MAX_KERNEL > 7) ? 7 : MAX_KERNEL;
  localparam int PIX_DEPTH = H_LIM * W_LIM;
  localparam int PADDR_W   = (PIX_DEPTH > 1) ? $clog2(PIX_DEPTH) : 1;
  localparam int PCNT_W    = $clog2(PIX_DEPTH + 1);
  localparam int TOT_W     = 2 * DIM_W;
  localparam int K_DEPTH   = K_LIM * K_LIM;
  localparam int CADDR_W   = (K_DEPTH > 1) ? $clog2(K_DEPTH) : 1;
  localparam int KCNT_W    = $clog2(K_DEPTH + 1);
  localparam int KTOT_W    = 2 * KDIM_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DIV   = 5'b00010,
    S_RUN   = 5'b00100,
    S_DRAIN = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  state_t state_r;

  logic [DIM_W-1:0]  img_h_r, img_w_r;
  logic [KDIM_W-1:0] ker_h_r, ker_w_r;
  logic [DIM_W-1:0]  h_eff, w_eff;
  logic [KDIM_W-1:0] kh_eff, kw_eff;
  logic [TOT_W-1:0]  itotal;
  logic [KTOT_W-1:0] ktotal;

  logic [KCNT_W-1:0] coef_cnt_r, coef_pos, coef_cnt_nxt;
  logic [KTOT_W-1:0] coef_pos_inc;
  logic [PCNT_W-1:0] pix_cnt_r, pix_pos, pix_cnt_nxt;
  logic [TOT_W-1:0]  pix_pos_inc;
  logic [PCNT_W-1:0] out_cnt_r;
  logic [TOT_W-1:0]  out_pos_inc;
  logic              is_last;

  logic [DIM_W-1:0]  row_r, col_r;
  logic              coords_ok_r;
  logic [KDIM_W-1:0] ky_r, kx_r;
  logic [CADDR_W-1:0] ci_r;

  logic              in_acc, cfg_acc, coef_we, pix_we, out_req, out_free;
  logic              cnt_stale, div_start, div_done;
  logic [PCNT_W-1:0] div_quot;
  logic [DIM_W-1:0]  div_rem;

  logic signed [IDX_W-1:0] y_idx, x_idx;
  logic              s1_v_r, s2_v_r, s3_v_r;
  logic [DIM_W-1:0]  s1_yy_r, s1_xx_r;
  logic [CADDR_W-1:0] s1_ci_r;
  logic [TOT_W-1:0]  paddr;
  logic [7:0]        pix_rd_r;
  logic signed [15:0] coef_rd_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic [ACC_W-OUT_W:0]     acc_hi;
  logic signed [OUT_W-1:0]  sat_val;

  logic [7:0]        pix_mem [PIX_DEPTH];
  logic signed [15:0] coef_mem [K_DEPTH];

  out_word_t out_word_r;
  logic      out_valid_r;

  // clamped sizes
  assign h_eff  = (img_h_r == '0) ? DIM_W'(1) :
                  (img_h_r > DIM_W'(H_LIM)) ? DIM_W'(H_LIM) : img_h_r;
  assign w_eff  = (img_w_r == '0) ? DIM_W'(1) :
                  (img_w_r > DIM_W'(W_LIM)) ? DIM_W'(W_LIM) : img_w_r;
  assign kh_eff = (ker_h_r == '0) ? KDIM_W'(1) :
                  (ker_h_r > KDIM_W'(K_LIM)) ? KDIM_W'(K_LIM) : ker_h_r;
  assign kw_eff = (ker_w_r == '0) ? KDIM_W'(1) :
                  (ker_w_r > KDIM_W'(K_LIM)) ? KDIM_W'(K_LIM) : ker_w_r;
  assign itotal = TOT_W'(h_eff) * TOT_W'(w_eff);
  assign ktotal = KTOT_W'(kh_eff) * KTOT_W'(kw_eff);

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign coef_we   = in_acc && (in_word.kind == KIND_COEF);
  assign pix_we    = in_acc && (in_word.kind == KIND_PIX);
  assign out_req   = in_acc && (in_word.kind == KIND_OUT);
  assign out_free  = !out_valid_r || out_ready;

  // load positions, wrapping at the current totals
  assign coef_pos     = (KTOT_W'(coef_cnt_r) >= ktotal) ? '0 : coef_cnt_r;
  assign coef_pos_inc = KTOT_W'(coef_pos) + KTOT_W'(1);
  assign coef_cnt_nxt = (coef_pos_inc >= ktotal) ? '0 : KCNT_W'(coef_pos_inc);
  assign pix_pos      = (TOT_W'(pix_cnt_r) >= itotal) ? '0 : pix_cnt_r;
  assign pix_pos_inc  = TOT_W'(pix_pos) + TOT_W'(1);
  assign pix_cnt_nxt  = (pix_pos_inc >= itotal) ? '0 : PCNT_W'(pix_pos_inc);

  assign cnt_stale   = TOT_W'(out_cnt_r) >= itotal;
  assign div_start   = out_req && !cnt_stale && !coords_ok_r;
  assign out_pos_inc = TOT_W'(out_cnt_r) + TOT_W'(1);
  assign is_last     = (out_pos_inc == itotal);

  c2rg_divider #(.NUM_W(PCNT_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (out_cnt_r),
    .divisor  (w_eff),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // tap coordinates before mirroring
  assign y_idx = $signed(IDX_W'(row_r)) + $signed(IDX_W'(ky_r)) - $signed(IDX_W'(kh_eff >> 1));
  assign x_idx = $signed(IDX_W'(col_r)) + $signed(IDX_W'(kx_r)) - $signed(IDX_W'(kw_eff >> 1));
  assign paddr = TOT_W'(s1_yy_r) * TOT_W'(w_eff) + TOT_W'(s1_xx_r);

  always_ff @(posedge clk) begin
    if (pix_we) begin
      pix_mem[pix_pos[PADDR_W-1:0]] <= in_word.pixel;
    end
    pix_rd_r <= pix_mem[paddr[PADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[coef_pos[CADDR_W-1:0]] <= in_word.coefficient;
    end
    coef_rd_r <= coef_mem[s1_ci_r];
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_h_r <= DIM_W'(1);
      img_w_r <= DIM_W'(1);
      ker_h_r <= KDIM_W'(1);
      ker_w_r <= KDIM_W'(1);
    end else if (cfg_acc) begin
      case (cfg_index)
        CFG_IMG_H: img_h_r <= cfg_data;
        CFG_IMG_W: img_w_r <= cfg_data;
        CFG_KER_H: ker_h_r <= cfg_data[KDIM_W-1:0];
        CFG_KER_W: ker_w_r <= cfg_data[KDIM_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      coef_cnt_r  <= '0;
      pix_cnt_r   <= '0;
      out_cnt_r   <= '0;
      row_r       <= '0;
      col_r       <= '0;
      coords_ok_r <= 1'b1;
      ky_r        <= '0;
      kx_r        <= '0;
      ci_r        <= '0;
      s1_v_r      <= 1'b0;
    end else begin
      s1_v_r <= 1'b0;
      if (coef_we) begin
        coef_cnt_r <= coef_cnt_nxt;
      end
      if (pix_we) begin
        pix_cnt_r <= pix_cnt_nxt;
      end
      case (state_r)
        S_IDLE: begin
          if (out_req) begin
            ky_r <= '0;
            kx_r <= '0;
            ci_r <= '0;
            if (cnt_stale) begin
              out_cnt_r   <= '0;
              row_r       <= '0;
              col_r       <= '0;
              coords_ok_r <= 1'b1;
              state_r     <= S_RUN;
            end else if (coords_ok_r) begin
              state_r <= S_RUN;
            end else begin
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            row_r       <= DIM_W'(div_quot);
            col_r       <= div_rem;
            coords_ok_r <= 1'b1;
            state_r     <= S_RUN;
          end
        end
        S_RUN: begin
          s1_v_r  <= 1'b1;
          s1_yy_r <= mirror101(y_idx, h_eff);
          s1_xx_r <= mirror101(x_idx, w_eff);
          s1_ci_r <= ci_r;
          ci_r    <= ci_r + 1'b1;
          if (kx_r == kw_eff - 1'b1) begin
            kx_r <= '0;
            if (ky_r == kh_eff - 1'b1) begin
              state_r <= S_DRAIN;
            end else begin
              ky_r <= ky_r + 1'b1;
            end
          end else begin
            kx_r <= kx_r + 1'b1;
          end
        end
        S_DRAIN: begin
          if (!s1_v_r && !s2_v_r && !s3_v_r) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state_r <= S_IDLE;
            if (is_last) begin
              out_cnt_r <= '0;
              row_r     <= '0;
              col_r     <= '0;
            end else begin
              out_cnt_r <= PCNT_W'(out_pos_inc);
              if (col_r == w_eff - 1'b1) begin
                col_r <= '0;
                row_r <= row_r + 1'b1;
              end else begin
                col_r <= col_r + 1'b1;
              end
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (cfg_acc) begin
        coords_ok_r <= 1'b0;
      end
    end
  end

  // multiply-accumulate pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= coef_rd_r * $signed({1'b0, pix_rd_r});
    if (out_req) begin
      acc_r <= '0;
    end else if (s3_v_r) begin
      acc_r <= acc_r + {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    end
  end

  assign acc_hi  = acc_r[ACC_W-1:OUT_W-1];
  assign sat_val = ((&acc_hi) || !(|acc_hi)) ? acc_r[OUT_W-1:0] :
                   acc_r[ACC_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_FIN) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_FIN) && out_free) begin
      out_word_r.filtered <= sat_val;
      out_word_r.out_row  <= 8'(row_r);
      out_word_r.out_col  <= 8'(col_r);
      out_word_r.last     <= is_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

@@ src/c2rg_checker.sv @@
// Port-level checker for the convolution top level, with its bind.
module c2rg_checker import c2rg_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_word_t  in_word,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("stalled output word changed");

  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not idle after reset");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_word.kind == KIND_OUT) |=> !in_ready)
    else $error("input taken while computing an output");

  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_word.kind != KIND_OUT) |=> in_ready)
    else $error("load word stalled the input");

  a_rise_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result presented while still busy");

endmodule

bind conv2d_reflect_gray_top c2rg_checker u_c2rg_checker (.*);

@@ test/conv2d_reflect_gray_checker.sv @@
// Channel monitor for conv2d_reflect_gray_top: predicts every output word and checks it.
module conv2d_reflect_gray_checker import c2rg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  in_word_t           in_word,
  input  logic               out_valid,
  input  logic               out_ready,
  input  out_word_t          out_word,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [CFG_I_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]   cfg_data,
  output int                 mismatches,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IMG_MAX    = 256;
  localparam int KER_MAX    = 7;

  logic [7:0]         pix_mem  [0:IMG_MAX*IMG_MAX-1];
  logic signed [15:0] coef_mem [0:KER_MAX*KER_MAX-1];
  logic [DIM_W-1:0]   img_h, img_w;
  logic [KDIM_W-1:0]  ker_h, ker_w;
  int                 coef_pos, pix_pos, out_pos;
  out_word_t          expected_pixels [$];
  int                 err_count = 0;

  function automatic int clamp_dim(int v, int maxv);
    if (v < 1) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic int wrap_start(int count, int total);
    return (count >= total) ? 0 : count;
  endfunction

  // reflect-101, folded as often as needed
  function automatic int reflect_coord(int idx, int size);
    int period;
    int m;
    if (size <= 1) return 0;
    period = 2 * size - 2;
    m = idx % period;
    if (m < 0) m += period;
    if (m >= size) m = period - m;
    return m;
  endfunction

  function automatic out_word_t convolve_next();
    int        h, w, kh, kw, total, pos, y, x, yy, xx;
    longint    acc;
    out_word_t r;
    h     = clamp_dim(img_h, IMG_MAX);
    w     = clamp_dim(img_w, IMG_MAX);
    kh    = clamp_dim(ker_h, KER_MAX);
    kw    = clamp_dim(ker_w, KER_MAX);
    total = h * w;
    pos   = wrap_start(out_pos, total);
    y     = pos / w;
    x     = pos % w;
    acc   = 0;
    for (int ky = 0; ky < kh; ky++) begin
      yy = reflect_coord(y + ky - kh / 2, h);
      for (int kx = 0; kx < kw; kx++) begin
        xx = reflect_coord(x + kx - kw / 2, w);
        acc += longint'(pix_mem[yy * w + xx]) * longint'(coef_mem[ky * kw + kx]);
      end
    end
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    r.filtered = 32'(acc);
    r.out_row  = 8'(y);
    r.out_col  = 8'(x);
    r.last     = (pos + 1 == total);
    out_pos    = wrap_start(pos + 1, total);
    return r;
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input longint got, input longint want,
                             input out_word_t ref_word);
    if (got != want)
      report_error($sformatf("%s at row %0d col %0d: got %0d, expected %0d",
                             name, ref_word.out_row, ref_word.out_col, got, want));
  endtask

  always @(posedge clk) begin : watch
    out_word_t want;
    int        h, w, kh, kw, pos;
    if (!rst_n) begin
      img_h    = 9'd1;
      img_w    = 9'd1;
      ker_h    = 3'd1;
      ker_w    = 3'd1;
      coef_pos = 0;
      pix_pos  = 0;
      out_pos  = 0;
      expected_pixels.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          report_error($sformatf("unexpected output word: filtered %0d row %0d col %0d",
                                 out_word.filtered, out_word.out_row, out_word.out_col));
        end else begin
          want = expected_pixels.pop_front();
          check_field("filtered", out_word.filtered, want.filtered, want);
          check_field("out_row", out_word.out_row, want.out_row, want);
          check_field("out_col", out_word.out_col, want.out_col, want);
          check_field("last", out_word.last, want.last, want);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_IMG_H: img_h = cfg_data;
          CFG_IMG_W: img_w = cfg_data;
          CFG_KER_H: ker_h = cfg_data[KDIM_W-1:0];
          CFG_KER_W: ker_w = cfg_data[KDIM_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        h  = clamp_dim(img_h, IMG_MAX);
        w  = clamp_dim(img_w, IMG_MAX);
        kh = clamp_dim(ker_h, KER_MAX);
        kw = clamp_dim(ker_w, KER_MAX);
        case (in_word.kind)
          KIND_COEF: begin
            pos           = wrap_start(coef_pos, kh * kw);
            coef_mem[pos] = in_word.coefficient;
            coef_pos      = wrap_start(pos + 1, kh * kw);
          end
          KIND_PIX: begin
            pos          = wrap_start(pix_pos, h * w);
            pix_mem[pos] = in_word.pixel;
            pix_pos      = wrap_start(pos + 1, h * w);
          end
          KIND_OUT: expected_pixels.push_back(convolve_next());
          default: ;
        endcase
      end
    end
    mismatches <= err_count;
    pending    <= expected_pixels.size();
  end

endmodule

@@ test/conv2d_reflect_gray_top_test.sv @@
// Testbench top for conv2d_reflect_gray_top: clock, reset, stimulus and the verdict.
module conv2d_reflect_gray_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import c2rg_pkg::*;

  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam int IMG_MAX       = 256;
  localparam int KER_MAX       = 7;
  localparam int SETTLE_CYCLES = 80;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int ITEM_TARGET   = 2100;
  localparam int PACE_SPAN     = 97;

  typedef enum int {PACE_FULL, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH} pace_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  in_word_t           in_word;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_word_t          out_word;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CFG_I_W-1:0] cfg_index;
  logic [DIM_W-1:0]   cfg_data;
  int                 mismatches;
  int                 pending;

  int items_sent = 0;
  int send_idle  = 0;
  int stall_pct  = 0;
  int cycles     = 0;

  conv2d_reflect_gray_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  conv2d_reflect_gray_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_word   (out_word),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  function automatic in_word_t make_word(logic [1:0] kind, logic [15:0] coef, logic [7:0] pix);
    in_word_t w;
    w.kind        = kind;
    w.coefficient = coef;
    w.pixel       = pix;
    return w;
  endfunction

  function automatic in_word_t rand_word(logic [1:0] kind);
    return make_word(kind, 16'($urandom), 8'($urandom));
  endfunction

  // sizes of 1 may go in as 0, the maximum as anything above it
  function automatic logic [DIM_W-1:0] img_data(int v, bit odd);
    if (v == 1 && (odd || $urandom_range(3) == 0)) return '0;
    if (v == IMG_MAX && (odd || $urandom_range(3) == 0))
      return DIM_W'($urandom_range(IMG_MAX + 1, (1 << DIM_W) - 1));
    return DIM_W'(v);
  endfunction

  // upper bits are junk; only the low kernel bits count
  function automatic logic [DIM_W-1:0] ker_data(int k, bit odd);
    logic [DIM_W-1:0] d;
    d = DIM_W'($urandom);
    d[KDIM_W-1:0] = (k == 1 && (odd || $urandom_range(1) == 1)) ? '0 : KDIM_W'(k);
    return d;
  endfunction

  task automatic send_word(input in_word_t w);
    int gaps = 0;
    case (pace_t'((items_sent / PACE_SPAN) % 4))
      PACE_FULL:       begin send_idle = 0;  stall_pct = 0;  end
      PACE_SEND_IDLE:  begin send_idle = 45; stall_pct = 0;  end
      PACE_RECV_STALL: begin send_idle = 0;  stall_pct = 45; end
      default:         begin send_idle = 18; stall_pct = 18; end
    endcase
    while ($urandom_range(99) < send_idle) gaps++;
    if (gaps > 0) begin
      in_valid <= 1'b0;
      repeat (gaps) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    if (w.kind != KIND_NONE) items_sent++;
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_I_W-1:0] idx, input logic [DIM_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_sizes(input int h, input int w, input int kh, input int kw, input bit odd);
    quiesce();
    if (odd) cfg_write(CFG_KER_W + CFG_I_W'($urandom_range(1, 4)), DIM_W'($urandom));
    cfg_write(CFG_IMG_H, img_data(h, odd));
    cfg_write(CFG_IMG_W, img_data(w, odd));
    cfg_write(CFG_KER_H, ker_data(kh, odd));
    cfg_write(CFG_KER_W, ker_data(kw, odd));
    cfg_valid <= 1'b0;
  endtask

  // a full pass of each store, coefficient and pixel words interleaved
  task automatic load_stores(input int n_coef, input int n_pix);
    while (n_coef + n_pix > 0) begin
      if (n_pix == 0 || (n_coef > 0 && $urandom_range(1) == 1)) begin
        send_word(rand_word(KIND_COEF));
        n_coef--;
      end else begin
        send_word(rand_word(KIND_PIX));
        n_pix--;
      end
    end
  endtask

  task automatic run_mix(input int n, input int out_pct);
    int r;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < out_pct) send_word(rand_word(KIND_OUT));
      else if (r < out_pct + 4) send_word(rand_word(KIND_NONE));
      else if ($urandom_range(1) == 1) send_word(rand_word(KIND_COEF));
      else send_word(rand_word(KIND_PIX));
    end
  endtask

  task automatic run_phase(input int h, input int w, input int kh, input int kw, input bit odd,
                           input int n, input int out_pct);
    set_sizes(h, w, kh, kw, odd);
    load_stores(kh * kw, h * w);
    run_mix(n, out_pct);
  endtask

  initial begin
    int h, w;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_word   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_IMG_H;
    cfg_data  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset sizes: 1x1 image, 1x1 kernel
    send_word(make_word(KIND_COEF, 16'h7FFF, 8'($urandom)));
    send_word(make_word(KIND_PIX, 16'($urandom), 8'hFF));
    send_word(rand_word(KIND_OUT));
    send_word(make_word(KIND_COEF, 16'h8000, 8'($urandom)));
    send_word(rand_word(KIND_OUT));
    send_word(make_word(KIND_PIX, 16'($urandom), 8'h00));
    send_word(rand_word(KIND_NONE));
    send_word(rand_word(KIND_OUT));

    // 3x3 kernel over a 2x2 image: every output has taps that fold back in
    set_sizes(2, 2, 3, 3, 1'b0);
    for (int i = 0; i < 9; i++)
      send_word(make_word(KIND_COEF, (i % 3 == 0) ? 16'h7FFF :
                          (i % 3 == 1) ? 16'h8000 : 16'($urandom), 8'($urandom)));
    send_word(make_word(KIND_PIX, 16'($urandom), 8'hFF));
    send_word(make_word(KIND_PIX, 16'($urandom), 8'h00));
    send_word(make_word(KIND_PIX, 16'($urandom), 8'h80));
    send_word(make_word(KIND_PIX, 16'($urandom), 8'h7F));
    repeat (5) send_word(rand_word(KIND_OUT));

    // largest sizes as a column, then as a row with out-of-range register values, then small ones
    run_phase(IMG_MAX, 1, KER_MAX, KER_MAX, 1'b0, 330, 85);
    run_phase(1, IMG_MAX, KER_MAX, KER_MAX, 1'b1, 330, 85);
    run_phase($urandom_range(1, 6), $urandom_range(1, 6), 1, 1, 1'b1, 40, 50);

    while (items_sent < ITEM_TARGET) begin
      h = ($urandom_range(1) == 1) ? $urandom_range(1, 4) : $urandom_range(1, 12);
      w = ($urandom_range(1) == 1) ? $urandom_range(1, 4) : $urandom_range(1, 12);
      run_phase(h, w, $urandom_range(1, KER_MAX), $urandom_range(1, KER_MAX),
                $urandom_range(7) == 0, $urandom_range(30, 90), 50);
    end

    quiesce();
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
